### src/hid_keyboard_report_builder_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the HID keyboard report builder
// Clock is clock, reset is reset (synchronous, active high).
// ---------------------------------------------------------------------------
`ifndef HID_KEYBOARD_REPORT_BUILDER_ASSERT_SVH
`define HID_KEYBOARD_REPORT_BUILDER_ASSERT_SVH

// same-cycle implication
`define HKRB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HKRB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/hkrb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hkrb_pkg
// Types, codes and the ASCII usage table of the keyboard report builder.
// ---------------------------------------------------------------------------
package hkrb_pkg;

   localparam int SHOWN_SLOTS = 6;

   localparam logic [1:0] ACT_PRESS       = 2'd0;
   localparam logic [1:0] ACT_RELEASE     = 2'd1;
   localparam logic [1:0] ACT_RELEASE_ALL = 2'd2;
   localparam logic [1:0] ACT_TYPE        = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_UNMAPPED = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   localparam logic [7:0] CODE_NONPRINT = 8'd136;
   localparam logic [7:0] CODE_MODIFIER = 8'd128;
   localparam logic [7:0] LEFT_SHIFT    = 8'h02;
   localparam logic [6:0] USAGE_EMPTY   = 7'h00;

   // bit 7 set: character needs left shift
   localparam logic [7:0] ASCII_USAGE [128] = '{
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h2c, 8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34,
      8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
      8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
      8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8,
      8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
      8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
      8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
      8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
      8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
      8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
      8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
      8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
   };

   // decoded key code
   typedef struct packed {
      logic       mapped;
      logic [6:0] usage;
      logic [7:0] modmask;
   } dec_type;

   // broadcast to every slot cell
   typedef struct packed {
      logic       press;
      logic       release_key;
      logic       clear;
      logic [6:0] usage;
   } cell_cmd_type;

   // rippled from cell to cell
   typedef struct packed {
      logic present;
      logic claimed;
   } chain_type;

endpackage

### src/hkrb_decode.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hkrb_decode
// Splits a key code into usage, modifier mask and a mapped flag.
// ---------------------------------------------------------------------------
module hkrb_decode (
   input  logic [7:0]       key_code,
   output hkrb_pkg::dec_type dec
);
   import hkrb_pkg::*;

   logic [7:0] ascii_entry;

   assign ascii_entry = ASCII_USAGE[key_code[6:0]];

   always_comb begin
      dec = '0;
      if (key_code >= CODE_NONPRINT) begin
         dec.mapped  = 1'b1;
         dec.usage   = 7'(key_code - CODE_NONPRINT);
         dec.modmask = '0;
      end else if (key_code >= CODE_MODIFIER) begin
         dec.mapped  = 1'b1;
         dec.usage   = USAGE_EMPTY;
         dec.modmask = 8'b1 << key_code[2:0];
      end else begin
         dec.mapped  = (ascii_entry != 8'h00);
         dec.usage   = ascii_entry[6:0];
         dec.modmask = ascii_entry[7] ? LEFT_SHIFT : 8'h00;
      end
   end

endmodule

### src/hkrb_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hkrb_cell
// One key slot; passes match and free-slot claims to its right neighbor.
// ---------------------------------------------------------------------------
module hkrb_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  hkrb_pkg::cell_cmd_type cmd,
   input  logic                   present_all,
   input  hkrb_pkg::chain_type    chain_in,
   output hkrb_pkg::chain_type    chain_out,
   output logic [6:0]             slot_next
);
   import hkrb_pkg::*;

   logic [6:0] slot_ff;
   logic [6:0] slot_in;
   logic       match;
   logic       empty;

   assign match = (slot_ff == cmd.usage);
   assign empty = (slot_ff == USAGE_EMPTY);

   assign chain_out.present = chain_in.present | match;
   assign chain_out.claimed = chain_in.claimed | empty;

   always_comb begin
      slot_in = slot_ff;
      if (cmd.clear) begin
         slot_in = USAGE_EMPTY;
      end else if (cmd.press && !present_all && empty && !chain_in.claimed) begin
         slot_in = cmd.usage;
      end else if (cmd.release_key && (cmd.usage != USAGE_EMPTY) && match) begin
         slot_in = USAGE_EMPTY;
      end
   end

   assign slot_next = slot_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= USAGE_EMPTY;
      end else begin
         slot_ff <= slot_in;
      end
   end

endmodule

### src/hid_keyboard_report_builder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hid_keyboard_report_builder
// 6-key-rollover boot keyboard report kept in a row of slot cells.
// ---------------------------------------------------------------------------
// A request is taken when the block is idle; it latches action and key code,
// then makes one report update per report it produces. With the request in
// the state and code registers, the report is updated and the response
// register loaded once that register is free. Press, release and release all
// give one response each; type gives a press response and then a release
// response, the release being loaded at the edge where the press response is
// taken. A new request can be taken while the last response still waits. The
// rate is set by the single report update stage, which both halves of a type
// share, and by rsp_stall, which holds that stage while the response
// register is full. Slot search is a ripple through KEY_SLOTS cells: each
// cell reports whether it already holds the usage and whether an empty slot
// was seen to its left, so the first empty cell takes a new key. There is
// no clearing pass; reset empties every slot at once.
// ---------------------------------------------------------------------------
module hid_keyboard_report_builder #(
   parameter int KEY_SLOTS = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_action,
   input  logic [7:0] req_key_code,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_sent,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_modifiers,
   output logic [6:0] rsp_key_slot0,
   output logic [6:0] rsp_key_slot1,
   output logic [6:0] rsp_key_slot2,
   output logic [6:0] rsp_key_slot3,
   output logic [6:0] rsp_key_slot4,
   output logic [6:0] rsp_key_slot5,
   output logic       rsp_last
);
   import hkrb_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE    = 4'b0001,
      S_PRESS   = 4'b0010,
      S_RELEASE = 4'b0100,
      S_CLEAR   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      typing_ff, typing_in;
   logic [7:0] code_ff, code_in;
   logic [7:0] mod_ff, mod_in;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_sent_ff, rsp_sent_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [7:0] rsp_mod_ff;
   logic       rsp_last_ff, rsp_last_in;
   logic [6:0] rsp_slot_ff [SHOWN_SLOTS];
   logic [6:0] shown_next [SHOWN_SLOTS];

   logic         req_accept;
   logic         out_free;
   logic         commit;
   logic         full;
   logic         present_all;
   dec_type      dec;
   cell_cmd_type cmd;
   chain_type    chain [KEY_SLOTS+1];
   logic [6:0]   slot_next [KEY_SLOTS];

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign commit     = (state_ff != S_IDLE) && out_free;

   hkrb_decode u_decode (
      .key_code (code_ff),
      .dec      (dec)
   );

   // command seen by every cell; only active in the update cycle
   always_comb begin
      cmd.press       = commit && (state_ff == S_PRESS) && dec.mapped;
      cmd.release_key = commit && (state_ff == S_RELEASE) && dec.mapped;
      cmd.clear       = commit && (state_ff == S_CLEAR);
      cmd.usage       = dec.usage;
   end

   // some cell already holds the usage: nothing is added
   assign present_all = chain[KEY_SLOTS].present;

   assign chain[0] = '0;

   for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_cell
      hkrb_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .present_all (present_all),
         .chain_in    (chain[i]),
         .chain_out   (chain[i+1]),
         .slot_next   (slot_next[i])
      );
   end

   // slots past the configured count read as empty
   for (genvar i = 0; i < SHOWN_SLOTS; i++) begin : g_show
      if (i < KEY_SLOTS) begin : g_real
         assign shown_next[i] = slot_next[i];
      end else begin : g_none
         assign shown_next[i] = USAGE_EMPTY;
      end
   end

   // no match and no empty slot
   assign full = !chain[KEY_SLOTS].present && !chain[KEY_SLOTS].claimed;

   always_comb begin
      mod_in = mod_ff;
      if (cmd.clear) begin
         mod_in = 8'h00;
      end else if (cmd.press) begin
         mod_in = mod_ff | dec.modmask;
      end else if (cmd.release_key) begin
         mod_in = mod_ff & ~dec.modmask;
      end
   end

   always_comb begin
      if (state_ff == S_CLEAR) begin
         rsp_status_in = STATUS_OK;
      end else if (!dec.mapped) begin
         rsp_status_in = STATUS_UNMAPPED;
      end else if ((state_ff == S_PRESS) && full) begin
         rsp_status_in = STATUS_FULL;
      end else begin
         rsp_status_in = STATUS_OK;
      end
      rsp_sent_in = (rsp_status_in == STATUS_OK);
      rsp_last_in = !((state_ff == S_PRESS) && typing_ff);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      typing_in = typing_ff;
      code_in   = code_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               code_in   = req_key_code;
               typing_in = (req_action == ACT_TYPE);
               unique case (req_action)
                  ACT_PRESS, ACT_TYPE: state_in = S_PRESS;
                  ACT_RELEASE:         state_in = S_RELEASE;
                  ACT_RELEASE_ALL:     state_in = S_CLEAR;
                  default:             state_in = S_IDLE;
               endcase
            end
         end
         S_PRESS: begin
            if (commit) begin
               state_in = typing_ff ? S_RELEASE : S_IDLE;
            end
         end
         S_RELEASE, S_CLEAR: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         typing_ff    <= 1'b0;
         mod_ff       <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         typing_ff    <= typing_in;
         mod_ff       <= mod_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      if (commit) begin
         rsp_sent_ff   <= rsp_sent_in;
         rsp_status_ff <= rsp_status_in;
         rsp_mod_ff    <= mod_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_slot_ff   <= shown_next;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sent      = rsp_sent_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_modifiers = rsp_mod_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_key_slot0 = rsp_slot_ff[0];
   assign rsp_key_slot1 = rsp_slot_ff[1];
   assign rsp_key_slot2 = rsp_slot_ff[2];
   assign rsp_key_slot3 = rsp_slot_ff[3];
   assign rsp_key_slot4 = rsp_slot_ff[4];
   assign rsp_key_slot5 = rsp_slot_ff[5];

endmodule

### src/hkrb_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hkrb_checker
// Port-level checks of the keyboard report builder, bound to the top level.
// ---------------------------------------------------------------------------
`include "hid_keyboard_report_builder_assert.svh"

module hkrb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [1:0] req_action,
   input logic [7:0] req_key_code,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_sent,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_modifiers,
   input logic [6:0] rsp_key_slot0,
   input logic [6:0] rsp_key_slot1,
   input logic [6:0] rsp_key_slot2,
   input logic [6:0] rsp_key_slot3,
   input logic [6:0] rsp_key_slot4,
   input logic [6:0] rsp_key_slot5,
   input logic       rsp_last
);
   import hkrb_pkg::*;

   logic [9:0]  req_payload;
   logic [53:0] rsp_payload;
   logic        sent_matches;
   logic        press_half_taken;
   logic        req_held;
   logic        rsp_held;

   assign req_payload      = {req_action, req_key_code};
   assign rsp_payload      = {rsp_sent, rsp_status, rsp_modifiers, rsp_key_slot5,
                              rsp_key_slot4, rsp_key_slot3, rsp_key_slot2,
                              rsp_key_slot1, rsp_key_slot0, rsp_last};
   assign sent_matches     = (rsp_sent == (rsp_status == STATUS_OK));
   assign press_half_taken = rsp_valid && !rsp_last && !rsp_stall;
   assign req_held         = req_valid && req_stall;
   assign rsp_held         = rsp_valid && rsp_stall;

   // sent exactly when status is ok
   `HKRB_ASSERT_NOW(a_sent_ok, rsp_valid, sent_matches, "sent/status mismatch")

   // release half of a type follows right after the press half is taken
   `HKRB_ASSERT_NEXT(a_type_pair, press_half_taken, rsp_valid && rsp_last, "type release missing")

   // no new request while a type is half done
   `HKRB_ASSERT_NOW(a_type_busy, rsp_valid && !rsp_last, req_stall, "request taken mid type")

   // stalled response holds
   `HKRB_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_payload), "response changed")

   // stalled request holds
   `HKRB_ASSERT_NEXT(a_req_hold, req_held, req_valid && $stable(req_payload), "request changed")

endmodule

bind hid_keyboard_report_builder hkrb_checker u_hkrb_checker (.*);

### test/hkrb_report_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hkrb_report_check
// Watches both channels of the keyboard report builder, keeps its own copy
// of the report, predicts the responses of every request and compares each
// response with the oldest prediction, field by field.
// ---------------------------------------------------------------------------
module hkrb_report_check #(
   parameter int KEY_SLOTS = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [1:0] req_action,
   input  logic [7:0] req_key_code,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_sent,
   input  logic [1:0] rsp_status,
   input  logic [7:0] rsp_modifiers,
   input  logic [6:0] rsp_key_slot0,
   input  logic [6:0] rsp_key_slot1,
   input  logic [6:0] rsp_key_slot2,
   input  logic [6:0] rsp_key_slot3,
   input  logic [6:0] rsp_key_slot4,
   input  logic [6:0] rsp_key_slot5,
   input  logic       rsp_last,
   output int         mismatch_count,
   output int         pending_reports
);
   import hkrb_pkg::*;

   typedef struct packed {
      logic                         sent;
      logic [1:0]                   status;
      logic [7:0]                   modifiers;
      logic [SHOWN_SLOTS-1:0][6:0]  slots;
      logic                         last;
   } report_type;

   // predicted keyboard state
   logic [7:0] held_mods;
   logic [6:0] held_slots [KEY_SLOTS];

   report_type expected_reports [$];

   task automatic report_mismatch(input string msg);
      $display("%0t ns: report check: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
   endtask

   function automatic void decode_key(input logic [7:0] code, output logic mapped,
                                      output logic [6:0] usage,
                                      output logic [7:0] modmask);
      logic [7:0] entry;
      entry = ASCII_USAGE[code[6:0]];
      mapped = 1'b1;
      usage = USAGE_EMPTY;
      modmask = '0;
      if (code >= CODE_NONPRINT) begin
         usage = 7'(code - CODE_NONPRINT);
      end else if (code >= CODE_MODIFIER) begin
         modmask = 8'b1 << (code - CODE_MODIFIER);
      end else begin
         // table bit 7 marks a shifted character
         mapped = (entry != 8'h00);
         usage = entry[6:0];
         if (entry[7])
            modmask = LEFT_SHIFT;
      end
   endfunction

   function automatic logic [1:0] press_key_code(input logic [7:0] code);
      logic       mapped;
      logic [6:0] usage;
      logic [7:0] modmask;
      logic       present;
      decode_key(code, mapped, usage, modmask);
      if (!mapped)
         return STATUS_UNMAPPED;
      held_mods |= modmask;
      // an empty slot matches usage 0, so modifiers only fail when full
      present = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++)
         if (held_slots[i] == usage)
            present = 1'b1;
      if (present)
         return STATUS_OK;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (held_slots[i] == USAGE_EMPTY) begin
            held_slots[i] = usage;
            return STATUS_OK;
         end
      end
      return STATUS_FULL;
   endfunction

   function automatic logic [1:0] release_key_code(input logic [7:0] code);
      logic       mapped;
      logic [6:0] usage;
      logic [7:0] modmask;
      decode_key(code, mapped, usage, modmask);
      if (!mapped)
         return STATUS_UNMAPPED;
      held_mods &= ~modmask;
      if (usage != USAGE_EMPTY)
         for (int i = 0; i < KEY_SLOTS; i++)
            if (held_slots[i] == usage)
               held_slots[i] = USAGE_EMPTY;
      return STATUS_OK;
   endfunction

   function automatic report_type snapshot(input logic [1:0] status, input logic last);
      report_type r;
      r.sent = (status == STATUS_OK);
      r.status = status;
      r.modifiers = held_mods;
      for (int i = 0; i < SHOWN_SLOTS; i++)
         r.slots[i] = (i < KEY_SLOTS) ? held_slots[i] : USAGE_EMPTY;
      r.last = last;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      report_type got;
      report_type want;
      logic [1:0] st;
      if (reset) begin
         held_mods = '0;
         for (int i = 0; i < KEY_SLOTS; i++)
            held_slots[i] = USAGE_EMPTY;
         expected_reports.delete();
      end else begin
         // responses first: a request taken at this edge cannot answer yet
         if (rsp_valid && !rsp_stall) begin
            got.sent = rsp_sent;
            got.status = rsp_status;
            got.modifiers = rsp_modifiers;
            got.slots = {rsp_key_slot5, rsp_key_slot4, rsp_key_slot3,
                         rsp_key_slot2, rsp_key_slot1, rsp_key_slot0};
            got.last = rsp_last;
            if (expected_reports.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = expected_reports.pop_front();
               check_field("sent", 32'(got.sent), 32'(want.sent));
               check_field("status", 32'(got.status), 32'(want.status));
               check_field("modifiers", 32'(got.modifiers), 32'(want.modifiers));
               for (int i = 0; i < SHOWN_SLOTS; i++)
                  check_field($sformatf("key_slot%0d", i), 32'(got.slots[i]),
                              32'(want.slots[i]));
               check_field("last", 32'(got.last), 32'(want.last));
            end
         end
         if (req_valid && !req_stall) begin
            case (req_action)
               ACT_PRESS: begin
                  st = press_key_code(req_key_code);
                  expected_reports.push_back(snapshot(st, 1'b1));
               end
               ACT_RELEASE: begin
                  st = release_key_code(req_key_code);
                  expected_reports.push_back(snapshot(st, 1'b1));
               end
               ACT_RELEASE_ALL: begin
                  held_mods = '0;
                  for (int i = 0; i < KEY_SLOTS; i++)
                     held_slots[i] = USAGE_EMPTY;
                  expected_reports.push_back(snapshot(STATUS_OK, 1'b1));
               end
               default: begin
                  // type: release happens whatever the press gave
                  st = press_key_code(req_key_code);
                  expected_reports.push_back(snapshot(st, 1'b0));
                  st = release_key_code(req_key_code);
                  expected_reports.push_back(snapshot(st, 1'b1));
               end
            endcase
         end
      end
      pending_reports = expected_reports.size();
   end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives key requests into the keyboard report builder with random gaps and
// random response back-pressure; a report checker beside the block predicts
// and compares every response, and this top gives the verdict.
// ---------------------------------------------------------------------------
module testbench;
   import hkrb_pkg::*;

   localparam int RANDOM_ITEMS = 525;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_action = ACT_PRESS;
   logic [7:0] req_key_code = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_sent;
   logic [1:0] rsp_status;
   logic [7:0] rsp_modifiers;
   logic [6:0] rsp_key_slot0;
   logic [6:0] rsp_key_slot1;
   logic [6:0] rsp_key_slot2;
   logic [6:0] rsp_key_slot3;
   logic [6:0] rsp_key_slot4;
   logic [6:0] rsp_key_slot5;
   logic       rsp_last;

   int mismatch_count;
   int pending_reports;

   // sender calm stretch: requests back to back
   int unsigned calm_items = 0;
   // recently pressed codes, so releases often hit a held key
   logic [7:0] recent_keys [8] = '{default: 8'h00};
   int unsigned recent_wr = 0;

   always #10 clock = ~clock;

   hid_keyboard_report_builder u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_key_code  (req_key_code),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sent      (rsp_sent),
      .rsp_status    (rsp_status),
      .rsp_modifiers (rsp_modifiers),
      .rsp_key_slot0 (rsp_key_slot0),
      .rsp_key_slot1 (rsp_key_slot1),
      .rsp_key_slot2 (rsp_key_slot2),
      .rsp_key_slot3 (rsp_key_slot3),
      .rsp_key_slot4 (rsp_key_slot4),
      .rsp_key_slot5 (rsp_key_slot5),
      .rsp_last      (rsp_last)
   );

   hkrb_report_check u_report_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_key_code    (req_key_code),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sent        (rsp_sent),
      .rsp_status      (rsp_status),
      .rsp_modifiers   (rsp_modifiers),
      .rsp_key_slot0   (rsp_key_slot0),
      .rsp_key_slot1   (rsp_key_slot1),
      .rsp_key_slot2   (rsp_key_slot2),
      .rsp_key_slot3   (rsp_key_slot3),
      .rsp_key_slot4   (rsp_key_slot4),
      .rsp_key_slot5   (rsp_key_slot5),
      .rsp_last        (rsp_last),
      .mismatch_count  (mismatch_count),
      .pending_reports (pending_reports)
   );

   // idle length shared by sender gaps and receiver stalls:
   // mostly short, now and then long
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 70)
         return $urandom_range(1, 2);
      if (r < 94)
         return $urandom_range(3, 8);
      return $urandom_range(15, 40);
   endfunction

   // key code mix: printable ASCII, any ASCII (some unmapped), modifiers,
   // a narrow band of non-printing keys so presses collide, and the full band
   function automatic logic [7:0] random_key_code();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 35)
         return 8'($urandom_range(32, 126));
      if (r < 45)
         return 8'($urandom_range(0, 127));
      if (r < 60)
         return 8'($urandom_range(128, 135));
      if (r < 80)
         return 8'($urandom_range(136, 150));
      return 8'($urandom_range(136, 255));
   endfunction

   // One request: optional gap with valid low, then valid high until taken.
   // Inputs only move at the falling edge; acceptance is seen at the rising
   // edge from the values that stood before it.
   task automatic send_request(input logic [1:0] act, input logic [7:0] code);
      int unsigned gap;
      gap = 0;
      if (calm_items > 0) begin
         calm_items--;
      end else begin
         if ($urandom_range(99) >= 55)
            gap = idle_len();
         if ($urandom_range(39) == 0)
            calm_items = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_action <= 2'($urandom);
         req_key_code <= 8'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_action <= act;
      req_key_code <= code;
      do @(posedge clock); while (req_stall);
   endtask

   // hold off the sender until every predicted response has come back
   task automatic drain_reports();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_reports == 0);
   endtask

   // Receiver back-pressure: random stalls, plus quiet stretches without any.
   initial begin : rsp_stall_gen
      int unsigned hold;
      int unsigned quiet;
      int unsigned r;
      logic        stall_next;
      hold = 0;
      quiet = 0;
      forever begin
         @(negedge clock);
         stall_next = 1'b0;
         if (hold > 0) begin
            hold--;
            stall_next = 1'b1;
         end else if (quiet > 0) begin
            quiet--;
         end else begin
            r = $urandom_range(99);
            if (r < 20) begin
               stall_next = 1'b1;
               hold = idle_len() - 1;
            end else if (r < 23) begin
               quiet = $urandom_range(20, 80);
            end
         end
         rsp_stall <= stall_next;
      end
   end

   initial begin : stimulus
      int unsigned phase;
      int unsigned r;
      logic [1:0]  act;
      logic [7:0]  code;
      phase = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed part ---
      send_request(ACT_PRESS, 8'h61);        // 'a': plain letter, usage 4
      send_request(ACT_PRESS, 8'h41);        // 'A': same usage, sets left shift
      send_request(ACT_PRESS, 8'd128);       // lowest modifier bit
      send_request(ACT_PRESS, 8'd135);       // highest modifier bit
      send_request(ACT_PRESS, 8'd136);       // non-printing usage 0: counts as held
      send_request(ACT_PRESS, 8'hFF);        // top non-printing code
      send_request(ACT_PRESS, 8'h62);
      send_request(ACT_PRESS, 8'h63);
      send_request(ACT_PRESS, 8'h64);
      send_request(ACT_PRESS, 8'h65);        // last free slot taken
      send_request(ACT_PRESS, 8'h66);        // no free slot
      send_request(ACT_PRESS, 8'd129);       // full, but the modifier bit sticks
      send_request(ACT_PRESS, 8'd136);       // usage 0 with no empty slot: full
      send_request(ACT_TYPE, 8'h67);         // type while full: press fails, release ok
      send_request(ACT_PRESS, 8'h00);        // unmapped control character
      send_request(ACT_RELEASE, 8'h7F);      // unmapped on release
      send_request(ACT_TYPE, 8'h01);         // unmapped on both halves of type
      send_request(ACT_RELEASE, 8'h63);      // frees a middle slot
      send_request(ACT_RELEASE, 8'h41);      // clears left shift and usage 4
      send_request(ACT_RELEASE, 8'd136);     // usage 0 clears no slot
      send_request(ACT_RELEASE, 8'd135);
      send_request(ACT_TYPE, 8'h21);         // '!' shifted character
      send_request(ACT_RELEASE_ALL, 8'hFF);  // key code ignored
      send_request(ACT_TYPE, 8'h7E);         // '~'
      send_request(ACT_RELEASE_ALL, 8'h00);
      drain_reports();

      // --- random part ---
      // Blocks of 25 requests, each in one style: rollover (mostly presses,
      // drives the slots full), typing (mostly type), or a free mix.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 25 == 0)
            phase = $urandom_range(2);
         if (n % 100 == 50)
            drain_reports();
         r = $urandom_range(99);
         case (phase)
            0: act = (r < 70) ? ACT_PRESS : (r < 90) ? ACT_RELEASE :
                     (r < 95) ? ACT_TYPE : ACT_RELEASE_ALL;
            1: act = (r < 75) ? ACT_TYPE : (r < 85) ? ACT_PRESS :
                     (r < 95) ? ACT_RELEASE : ACT_RELEASE_ALL;
            default: act = (r < 40) ? ACT_PRESS : (r < 65) ? ACT_RELEASE :
                           (r < 90) ? ACT_TYPE : ACT_RELEASE_ALL;
         endcase
         code = random_key_code();
         if (act == ACT_RELEASE && $urandom_range(2) != 0)
            code = recent_keys[$urandom_range(7)];
         if (act == ACT_PRESS) begin
            recent_keys[recent_wr] = code;
            recent_wr = (recent_wr + 1) % 8;
         end
         send_request(act, code);
      end

      // --- wind down: let every response come back, then give the verdict
      drain_reports();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_reports == 0)
         $display("[hid_keyboard_report_builder] OK");
      else
         $display("[hid_keyboard_report_builder] ERROR");
      $finish;
   end

   // run limit: several times the slowest legal run
   initial begin : run_limit
      #10_000_000;
      $display("[hid_keyboard_report_builder] ERROR");
      $finish;
   end

endmodule
